// File: hdl/eulerian_circuit_check_defines.svh
// Assertion macros shared by the Eulerian circuit check RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef EULERIAN_CIRCUIT_CHECK_DEFINES_SVH
`define EULERIAN_CIRCUIT_CHECK_DEFINES_SVH

// Same-cycle property, checked on every rising edge outside reset
`define ECC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle
`define ECC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ecc_pkg.sv
// Shared constants, payload and command types for the Eulerian circuit check.
// No dependencies; imported by the front, queue, back, top level and testbench.
package ecc_pkg;

  // Graph bounds
  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 4096;

  // Field widths fixed by the interface
  localparam int VTX_W  = 10;
  localparam int VCNT_W = 11;

  // Derived widths
  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int NV_W   = $clog2(MAX_VERTICES + 1);
  localparam int EDGE_W = $clog2(MAX_EDGES + 1);
  localparam int BAL_W  = EDGE_W + 1;
  localparam int JOIN_W = ADDR_W;

  // Command queue between front and back (power of two)
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);

  // Action codes
  localparam logic ACT_EDGE = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  // Verdict codes
  localparam logic [1:0] VERDICT_NO    = 2'd0;
  localparam logic [1:0] VERDICT_YES   = 2'd1;
  localparam logic [1:0] VERDICT_MIXED = 2'd2;

  typedef struct packed {
    logic             action;
    logic [VTX_W-1:0] source_vertex;
    logic [VTX_W-1:0] dest_vertex;
    logic             is_directed;
  } ecc_in_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       overflow;
  } ecc_out_t;

  // Work handed from front to back
  typedef struct packed {
    logic              is_eval;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic [NV_W-1:0]   scan_n;
    logic              need_scan;
    logic [1:0]        verdict;
    logic              all_directed;
    logic              dropped;
  } ecc_cmd_t;

  // One vertex entry: touched bit and two's complement balance (out minus in)
  typedef struct packed {
    logic             touched;
    logic [BAL_W-1:0] balance;
  } ecc_bal_t;

endpackage

// File: hdl/ecc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependency.
module ecc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/ecc_front.sv
// Front end: config register, edge counters, range and bound checks.
// Depends on ecc_pkg; pushes commands into ecc_queue.
module ecc_front import ecc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ecc_in_t           in_data_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [VCNT_W-1:0] cfg_data_i,
  input  logic              q_full_i,
  input  logic              init_done_i,
  output logic              push_o,
  output ecc_cmd_t          cmd_o
);

  logic [VCNT_W-1:0] vcount_q;
  logic [EDGE_W-1:0] edge_q;
  logic [EDGE_W-1:0] dir_q;
  logic              drop_q;

  logic [NV_W-1:0] n_eff;
  logic            accept;
  logic            is_eval;
  logic            at_bound;
  logic            in_range;

  // Clamp the vertex count to the store size
  assign n_eff = (32'(vcount_q) > MAX_VERTICES) ? NV_W'(MAX_VERTICES) : NV_W'(vcount_q);

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = init_done_i && !q_full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign is_eval     = (in_data_i.action == ACT_EVAL);
  assign at_bound    = (32'(edge_q) >= MAX_EDGES);
  assign in_range    = (32'(in_data_i.source_vertex) < 32'(n_eff)) &&
                       (32'(in_data_i.dest_vertex) < 32'(n_eff));

  // Forward evaluates and counted edges; drop the rest here
  assign push_o = accept && (is_eval || (!at_bound && in_range));

  // Classify an evaluate from the counters
  always_comb begin
    cmd_o              = '0;
    cmd_o.is_eval      = is_eval;
    cmd_o.src          = ADDR_W'(in_data_i.source_vertex);
    cmd_o.dst          = ADDR_W'(in_data_i.dest_vertex);
    cmd_o.scan_n       = n_eff;
    cmd_o.all_directed = (dir_q == edge_q);
    cmd_o.dropped      = drop_q;
    cmd_o.need_scan    = 1'b0;
    cmd_o.verdict      = VERDICT_NO;
    if (n_eff == '0) begin
      cmd_o.verdict = VERDICT_NO;
    end else if (edge_q == '0) begin
      cmd_o.verdict = VERDICT_YES;
    end else if (dir_q != '0 && dir_q != edge_q) begin
      cmd_o.verdict = VERDICT_MIXED;
    end else begin
      cmd_o.need_scan = 1'b1;
    end
  end

  // Update register and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
      edge_q   <= '0;
      dir_q    <= '0;
      drop_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        vcount_q <= cfg_data_i;
      end
      if (accept) begin
        if (is_eval) begin
          edge_q <= '0;
          dir_q  <= '0;
          drop_q <= 1'b0;
        end else if (at_bound) begin
          drop_q <= 1'b1;
        end else if (in_range) begin
          edge_q <= edge_q + EDGE_W'(1);
          if (in_data_i.is_directed) begin
            dir_q <= dir_q + EDGE_W'(1);
          end
        end
      end
    end
  end

endmodule

// File: hdl/ecc_queue.sv
// Short command queue between front and back, registers with a head read.
// Depends on ecc_pkg.
`include "eulerian_circuit_check_defines.svh"
module ecc_queue import ecc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ecc_cmd_t cmd_i,
  input  logic     pop_i,
  output ecc_cmd_t cmd_o,
  output logic     full_o,
  output logic     empty_o
);

  ecc_cmd_t          slot_q [Q_DEPTH];
  logic [QPTR_W-1:0] wr_q;
  logic [QPTR_W-1:0] rd_q;
  logic [QPTR_W:0]   cnt_q;

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPTR_W + 1)'(1);
      end
    end
  end

  assign cmd_o   = slot_q[rd_q];
  assign full_o  = (cnt_q == (QPTR_W + 1)'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);

  `ECC_ASSERT(a_push_room, push_i |-> !full_o, "command pushed into a full queue")
  `ECC_ASSERT(a_pop_data, pop_i |-> !empty_o, "command popped from an empty queue")

endmodule

// File: hdl/ecc_back.sv
// Back end: balance/touched and parent memories, union-find walks,
// evaluate scan with clearing sweep, and the result register.
// Depends on ecc_pkg and ecc_ram.
`include "eulerian_circuit_check_defines.svh"
module ecc_back import ecc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     empty_i,
  input  ecc_cmd_t cmd_i,
  output logic     pop_o,
  output logic     init_done_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ecc_out_t out_data_o
);

  localparam int BE_W = $bits(ecc_bal_t);

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_BU_WR = 3'd2;
  localparam logic [2:0] S_BW_WR = 3'd3;
  localparam logic [2:0] S_F_CHK = 3'd4;
  localparam logic [2:0] S_F_GP  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(MAX_VERTICES - 1);

  logic [2:0]        state_q, state_d;
  ecc_cmd_t          cmd_q, cmd_d;
  logic [ADDR_W-1:0] x_q, x_d;
  logic [ADDR_W-1:0] a_q, a_d;
  logic              walk_q, walk_d;
  logic [JOIN_W-1:0] join_q, join_d;
  logic [NV_W-1:0]   idx_q, idx_d;
  logic              chk_v_q, chk_v_d;
  logic [ADDR_W-1:0] chk_idx_q, chk_idx_d;
  logic              eval_q, eval_d;
  logic              bad_q, bad_d;
  logic [NV_W-1:0]   nt_q, nt_d;
  logic              init_done_q, init_done_d;
  logic              out_valid_q, out_valid_d;
  ecc_out_t          out_q, out_d;

  logic              bal_we;
  logic [ADDR_W-1:0] bal_waddr;
  ecc_bal_t          bal_wdata;
  logic [ADDR_W-1:0] bal_raddr;
  logic [BE_W-1:0]   bal_rraw;
  ecc_bal_t          bal_rd;
  logic              par_we;
  logic [ADDR_W-1:0] par_waddr;
  logic [ADDR_W-1:0] par_wdata;
  logic [ADDR_W-1:0] par_raddr;
  logic [ADDR_W-1:0] par_rd;
  logic              out_free;
  logic [1:0]        scan_verdict;

  ecc_ram #(.WIDTH(BE_W), .DEPTH(MAX_VERTICES)) u_bal_ram (
    .clk_i   (clk_i),
    .we_i    (bal_we),
    .waddr_i (bal_waddr),
    .wdata_i (bal_wdata),
    .raddr_i (bal_raddr),
    .rdata_o (bal_rraw)
  );

  ecc_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_VERTICES)) u_par_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (par_waddr),
    .wdata_i (par_wdata),
    .raddr_i (par_raddr),
    .rdata_o (par_rd)
  );

  assign bal_rd   = ecc_bal_t'(bal_rraw);
  assign out_free = !out_valid_q || out_ready_i;

  // Scan outcome: all balances (or parities) zero and one connected component
  always_comb begin
    if (bad_q || nt_q == '0) begin
      scan_verdict = VERDICT_NO;
    end else if (NV_W'(join_q) + NV_W'(1) == nt_q) begin
      scan_verdict = VERDICT_YES;
    end else begin
      scan_verdict = VERDICT_NO;
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    x_d         = x_q;
    a_d         = a_q;
    walk_d      = walk_q;
    join_d      = join_q;
    idx_d       = idx_q;
    chk_v_d     = 1'b0;
    chk_idx_d   = chk_idx_q;
    eval_d      = eval_q;
    bad_d       = bad_q;
    nt_d        = nt_q;
    init_done_d = init_done_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    pop_o       = 1'b0;
    bal_we      = 1'b0;
    bal_waddr   = '0;
    bal_wdata   = '0;
    bal_raddr   = '0;
    par_we      = 1'b0;
    par_waddr   = '0;
    par_wdata   = '0;
    par_raddr   = '0;

    case (state_q)
      S_SWEEP: begin
        // Read one entry ahead, check and clear the one read last cycle
        if (32'(idx_q) < MAX_VERTICES) begin
          bal_raddr = idx_q[ADDR_W-1:0];
          chk_v_d   = 1'b1;
          chk_idx_d = idx_q[ADDR_W-1:0];
          idx_d     = idx_q + NV_W'(1);
        end
        if (chk_v_q) begin
          bal_we    = 1'b1;
          bal_waddr = chk_idx_q;
          bal_wdata = '0;
          par_we    = 1'b1;
          par_waddr = chk_idx_q;
          par_wdata = chk_idx_q;
          if (eval_q && (32'(chk_idx_q) < 32'(cmd_q.scan_n))) begin
            if (cmd_q.all_directed ? (bal_rd.balance != '0) : bal_rd.balance[0]) begin
              bad_d = 1'b1;
            end
            if (bal_rd.touched) begin
              nt_d = nt_q + NV_W'(1);
            end
          end
          if (chk_idx_q == LAST_IDX) begin
            init_done_d = 1'b1;
            state_d     = eval_q ? S_DONE : S_IDLE;
          end
        end
      end

      S_IDLE: begin
        // Take the next command and start its first read
        if (!empty_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          if (cmd_i.is_eval) begin
            eval_d  = 1'b1;
            idx_d   = '0;
            bad_d   = 1'b0;
            nt_d    = '0;
            state_d = S_SWEEP;
          end else begin
            bal_raddr = cmd_i.src;
            state_d   = S_BU_WR;
          end
        end
      end

      S_BU_WR: begin
        // Source endpoint: count out-degree, or nothing for a self-loop
        bal_we            = 1'b1;
        bal_waddr         = cmd_q.src;
        bal_wdata.touched = 1'b1;
        if (cmd_q.src == cmd_q.dst) begin
          bal_wdata.balance = bal_rd.balance;
          par_raddr         = cmd_q.src;
          x_d               = cmd_q.src;
          walk_d            = 1'b0;
          state_d           = S_F_CHK;
        end else begin
          bal_wdata.balance = bal_rd.balance + BAL_W'(1);
          bal_raddr         = cmd_q.dst;
          state_d           = S_BW_WR;
        end
      end

      S_BW_WR: begin
        // Destination endpoint: count in-degree, start the first walk
        bal_we            = 1'b1;
        bal_waddr         = cmd_q.dst;
        bal_wdata.touched = 1'b1;
        bal_wdata.balance = bal_rd.balance - BAL_W'(1);
        par_raddr         = cmd_q.src;
        x_d               = cmd_q.src;
        walk_d            = 1'b0;
        state_d           = S_F_CHK;
      end

      S_F_CHK: begin
        if (par_rd == x_q) begin
          if (!walk_q) begin
            // Source root found; walk from the destination
            a_d       = x_q;
            walk_d    = 1'b1;
            x_d       = cmd_q.dst;
            par_raddr = cmd_q.dst;
          end else begin
            // Both roots known; join distinct trees
            if (a_q != x_q) begin
              par_we    = 1'b1;
              par_waddr = a_q;
              par_wdata = x_q;
              join_d    = join_q + JOIN_W'(1);
            end
            state_d = S_IDLE;
          end
        end else begin
          par_raddr = par_rd;
          state_d   = S_F_GP;
        end
      end

      S_F_GP: begin
        // Path halving: point x at its grandparent and move there
        par_we    = 1'b1;
        par_waddr = x_q;
        par_wdata = par_rd;
        x_d       = par_rd;
        par_raddr = par_rd;
        state_d   = S_F_CHK;
      end

      S_DONE: begin
        // Hand the verdict to the output register
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.verdict    = cmd_q.need_scan ? scan_verdict : cmd_q.verdict;
          out_d.overflow   = cmd_q.dropped;
          join_d           = '0;
          eval_d           = 1'b0;
          state_d          = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers; reset starts the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      idx_q       <= '0;
      chk_v_q     <= 1'b0;
      eval_q      <= 1'b0;
      join_q      <= '0;
      init_done_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      chk_v_q     <= chk_v_d;
      eval_q      <= eval_d;
      join_q      <= join_d;
      init_done_q <= init_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    x_q       <= x_d;
    a_q       <= a_d;
    walk_q    <= walk_d;
    chk_idx_q <= chk_idx_d;
    bad_q     <= bad_d;
    nt_q      <= nt_d;
    out_q     <= out_d;
  end

  assign init_done_o = init_done_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ECC_ASSERT(a_idle_quiet, (state_q == S_IDLE) |-> (!bal_we && !par_we), "memory write while idle")
  `ECC_ASSERT_NEXT(a_scan_to_done, state_q == S_SWEEP && chk_v_q && chk_idx_q == LAST_IDX && eval_q, state_q == S_DONE, "evaluate sweep did not end in result stage")

endmodule

// File: hdl/eulerian_circuit_check.sv
// Top level of the Eulerian circuit check: front, command queue and back.
// Depends on ecc_pkg, ecc_front, ecc_queue, ecc_back.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  ecc_in_t  (action, endpoints, directed)
//   out      output     out_valid_o/out_ready_i ecc_out_t (verdict, overflow)
//   cfg      input      cfg_valid_i/cfg_ready_o vertex_count, 11 bits
//
// Edge: the back end updates the source and destination entries (the source only
// for a self-loop), then walks both parent chains with path halving and joins
// distinct roots; dropped and out-of-range edges end in the front. Evaluate: one
// sweep over all MAX_VERTICES entries that checks and clears. Reset: a clearing
// pass with in_ready_o low; configuration writes are taken throughout.
// Stalls: a full queue stalls the input; a waiting result holds the next evaluate.
module eulerian_circuit_check import ecc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ecc_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ecc_out_t          out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [VCNT_W-1:0] cfg_data_i
);

  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;
  logic     init_done;
  ecc_cmd_t push_cmd;
  ecc_cmd_t head_cmd;

  ecc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .init_done_i (init_done),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  ecc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ecc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .init_done_o (init_done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/sv/eulerian_circuit_check_tb.sv
// Self-checking testbench for eulerian_circuit_check: streams edge and evaluate items,
// predicts each verdict in a behavioral graph store and compares every result.
// Depends on ecc_pkg and the eulerian_circuit_check RTL.
module eulerian_circuit_check_tb import ecc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES  = 2 * MAX_VERTICES + 64;
  localparam int unsigned HOLD_CYCLES    = 5000;
  localparam int unsigned RANDOM_ITEMS   = 1850;
  localparam int unsigned GRAPHS_PER_CFG = 12;

  typedef struct {
    ecc_in_t     item;
    int unsigned gap;
  } graph_slot_t;

  // DUT connections
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready_o;
  ecc_in_t           in_data     = '0;
  logic              out_valid_o;
  logic              out_ready   = 1'b0;
  ecc_out_t          out_data_o;
  logic              cfg_valid   = 1'b0;
  logic              cfg_ready_o;
  logic [VCNT_W-1:0] cfg_data    = '0;

  // Graph store mirror used for prediction
  logic signed [BAL_W-1:0] bal_mem    [MAX_VERTICES];
  bit                      touched_mem[MAX_VERTICES];
  logic [ADDR_W-1:0]       parent_mem [MAX_VERTICES];
  int unsigned             edge_cnt;
  int unsigned             directed_cnt;
  int unsigned             join_cnt;
  bit                      dropped;
  logic [VCNT_W-1:0]       vcount_reg = '0;

  // Items waiting for the driver, verdicts waiting for the monitor
  graph_slot_t graph_item_q[$];
  ecc_out_t    verdict_q[$];

  int unsigned pushed_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned loaded_items   = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned gap_left       = 0;
  int unsigned stall_left     = 0;
  int unsigned hold_left      = 0;
  bit          burst          = 1'b0;
  bit          calm           = 1'b0;
  logic        hold_request   = 1'b0;
  bit          hold_done      = 1'b0;

  eulerian_circuit_check i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Graph store mirror
  // ---------------------------------------------------------------------------

  function automatic void clear_graph();
    for (int unsigned i = 0; i < MAX_VERTICES; i++) begin
      bal_mem[i]     = '0;
      touched_mem[i] = 1'b0;
      parent_mem[i]  = i[ADDR_W-1:0];
    end
    edge_cnt     = 0;
    directed_cnt = 0;
    join_cnt     = 0;
    dropped      = 1'b0;
  endfunction

  // Clamp the register to the vertex bound
  function automatic int unsigned live_vertices();
    return (vcount_reg > MAX_VERTICES) ? MAX_VERTICES : int'(vcount_reg);
  endfunction

  // Walk to the root, halving the path on the way
  function automatic logic [ADDR_W-1:0] find_root(input logic [ADDR_W-1:0] x);
    logic [ADDR_W-1:0] v;
    v = x;
    while (parent_mem[v] != v) begin
      parent_mem[v] = parent_mem[parent_mem[v]];
      v = parent_mem[v];
    end
    return v;
  endfunction

  function automatic logic [1:0] judge_graph();
    int unsigned n;
    int unsigned seen;
    bit          all_dir;
    n    = live_vertices();
    seen = 0;
    if (n == 0) return VERDICT_NO;
    if (edge_cnt == 0) return VERDICT_YES;
    if (directed_cnt != 0 && directed_cnt != edge_cnt) return VERDICT_MIXED;
    all_dir = (directed_cnt == edge_cnt);
    // Directed graphs need zero balance, undirected ones even degree
    for (int unsigned i = 0; i < n; i++) begin
      if (all_dir ? (bal_mem[i] != '0) : bal_mem[i][0]) return VERDICT_NO;
      seen += touched_mem[i];
    end
    if (seen == 0) return VERDICT_NO;
    return (join_cnt == seen - 1) ? VERDICT_YES : VERDICT_NO;
  endfunction

  // Advance the mirror by one accepted item
  function automatic void apply_graph_item(input ecc_in_t it);
    ecc_out_t          result;
    int unsigned       n;
    logic [ADDR_W-1:0] ra;
    logic [ADDR_W-1:0] rb;
    if (it.action == ACT_EVAL) begin
      result.verdict  = judge_graph();
      result.overflow = dropped;
      verdict_q.push_back(result);
      clear_graph();
      return;
    end
    if (edge_cnt >= MAX_EDGES) begin
      dropped = 1'b1;
      return;
    end
    n = live_vertices();
    if (it.source_vertex >= n || it.dest_vertex >= n) return;
    edge_cnt++;
    if (it.is_directed) directed_cnt++;
    touched_mem[it.source_vertex] = 1'b1;
    touched_mem[it.dest_vertex]   = 1'b1;
    bal_mem[it.source_vertex]     = bal_mem[it.source_vertex] + 1;
    bal_mem[it.dest_vertex]       = bal_mem[it.dest_vertex] - 1;
    ra = find_root(it.source_vertex);
    rb = find_root(it.dest_vertex);
    if (ra != rb) begin
      parent_mem[ra] = rb;
      join_cnt++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void push_item(input logic action, input int unsigned src,
                                    input int unsigned dst, input logic dir);
    graph_slot_t slot;
    int unsigned lim;
    lim = live_vertices();
    slot.item.action        = action;
    slot.item.source_vertex = src[VTX_W-1:0];
    slot.item.dest_vertex   = dst[VTX_W-1:0];
    slot.item.is_directed   = dir;
    slot.gap = burst ? 0 : $urandom_range(0, 11);
    graph_item_q.push_back(slot);
    pushed_count++;
    // Ignored edges do not count toward the random total
    if (action == ACT_EVAL || (src < lim && dst < lim)) loaded_items++;
  endfunction

  function automatic void push_eval();
    push_item(ACT_EVAL, $urandom_range(0, MAX_VERTICES - 1),
              $urandom_range(0, MAX_VERTICES - 1), $urandom_range(0, 1));
  endfunction

  function automatic int unsigned pick_vertex(input int unsigned lim);
    return (lim == 0) ? $urandom_range(0, MAX_VERTICES - 1) : $urandom_range(0, lim - 1);
  endfunction

  function automatic int unsigned pick_vertex_count();
    int unsigned r;
    r = $urandom_range(0, 15);
    case (r)
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return MAX_VERTICES;
      4:       return $urandom_range(MAX_VERTICES + 1, (1 << VCNT_W) - 1);
      default: return $urandom_range(3, 48);
    endcase
  endfunction

  // Mostly closed walks, which pass every test unless no vertex is live; some broken or random graphs
  function automatic void load_random_graph();
    int unsigned lim;
    int unsigned kind;
    int unsigned len;
    int unsigned skip;
    int unsigned walk[10];
    logic        dir;
    logic        link_dir;
    lim   = live_vertices();
    burst = ($urandom_range(0, 5) == 0);
    kind  = $urandom_range(0, 9);
    len   = $urandom_range(1, 10);
    dir   = $urandom_range(0, 1);
    skip  = (kind == 6) ? $urandom_range(0, len - 1) : len;
    for (int unsigned i = 0; i < len; i++) walk[i] = pick_vertex(lim);
    for (int unsigned i = 0; i < len; i++) begin
      link_dir = dir;
      if (kind == 7 && i == 0) link_dir = !dir;
      if (kind == 9) link_dir = $urandom_range(0, 1);
      if (kind >= 8) begin
        push_item(ACT_EDGE, pick_vertex(lim), pick_vertex(lim), link_dir);
      end else if (i != skip) begin
        push_item(ACT_EDGE, walk[i], walk[(i + 1) % len], link_dir);
      end
      // Sprinkle edges with an endpoint out of range
      if (lim < MAX_VERTICES && $urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          push_item(ACT_EDGE, $urandom_range(lim, MAX_VERTICES - 1), pick_vertex(lim),
                    $urandom_range(0, 1));
        end else begin
          push_item(ACT_EDGE, pick_vertex(lim), $urandom_range(lim, MAX_VERTICES - 1),
                    $urandom_range(0, 1));
        end
      end
    end
    push_eval();
  endfunction

  // Hold until every item is taken, every verdict is back and the back end is quiet
  task automatic wait_idle();
    do @(posedge clk_i);
    while (accepted_count != pushed_count || verdict_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(input int unsigned value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value[VCNT_W-1:0];
    do @(posedge clk_i);
    while (!cfg_ready_o);
    vcount_reg = value[VCNT_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, driver, monitor, watchdog
  // ---------------------------------------------------------------------------

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Present queued items, mirror each one as it is taken
  always @(posedge clk_i or negedge rst_ni) begin : item_driver
    graph_slot_t slot;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready_o) begin
        apply_graph_item(in_data);
        accepted_count++;
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (graph_item_q.size() != 0) begin
          slot = graph_item_q.pop_front();
          in_valid <= 1'b1;
          in_data  <= slot.item;
          gap_left <= slot.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each result against the oldest verdict, then pick the next ready level
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    ecc_out_t    want;
    int unsigned draw;
    logic        next_ready;
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
      calm       <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t ns: result with no verdict pending, actual verdict %0d overflow %0d",
                   $time, out_data_o.verdict, out_data_o.overflow);
          mismatch_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_data_o.verdict !== want.verdict) begin
            $display("%0t ns: verdict mismatch, expected %0d, actual %0d",
                     $time, want.verdict, out_data_o.verdict);
            mismatch_count++;
          end
          if (out_data_o.overflow !== want.overflow) begin
            $display("%0t ns: overflow mismatch, expected %0d, actual %0d",
                     $time, want.overflow, out_data_o.overflow);
            mismatch_count++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        next_ready = (hold_left == 1);
      end else if (hold_request && !hold_done) begin
        // Long hold-off so the command queue fills and the input stalls
        hold_left  <= HOLD_CYCLES;
        hold_done  <= 1'b1;
        stall_left <= 0;
        next_ready = 1'b0;
      end else if (out_valid_o && out_ready) begin
        draw = calm ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 7) == 0) calm <= !calm;
        stall_left <= draw;
        next_ready = (draw == 0);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        next_ready = (stall_left == 1);
      end else begin
        next_ready = 1'b1;
      end
      out_ready <= next_ready;
    end
  end

  // Abort when no channel moves an item for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no item moved for %0d cycles", $time, idle_cycles);
        $display("eulerian_circuit_check regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_graph();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero vertices: verdict is no, and any edge is out of range
    burst = 1'b0;
    push_item(ACT_EDGE, 3, 7, 1'b1);
    push_eval();
    wait_idle();

    // Register above the bound acts as the bound
    write_vertex_count((1 << VCNT_W) - 1);
    push_eval();
    push_item(ACT_EDGE, MAX_VERTICES - 1, 0, 1'b1);
    push_item(ACT_EDGE, 0, MAX_VERTICES - 1, 1'b1);
    push_eval();
    push_item(ACT_EDGE, 512, 512, 1'b0);
    push_eval();
    push_item(ACT_EDGE, 1, 2, 1'b1);
    push_item(ACT_EDGE, 2, 1, 1'b0);
    push_eval();
    push_item(ACT_EDGE, 0, 1, 1'b0);
    push_item(ACT_EDGE, 1, 2, 1'b0);
    push_eval();
    push_item(ACT_EDGE, 0, 1, 1'b0);
    push_item(ACT_EDGE, 1, 0, 1'b0);
    push_item(ACT_EDGE, 2, 3, 1'b0);
    push_item(ACT_EDGE, 3, 2, 1'b0);
    push_eval();
    push_item(ACT_EDGE, 5, 6, 1'b1);
    push_item(ACT_EDGE, 6, 5, 1'b1);
    push_item(ACT_EDGE, 5, 6, 1'b1);
    push_eval();
    wait_idle();

    // Shrink the register while loaded: the scan then sees no touched vertex
    write_vertex_count(MAX_VERTICES);
    push_item(ACT_EDGE, 10, 11, 1'b1);
    push_item(ACT_EDGE, 11, 10, 1'b1);
    wait_idle();
    write_vertex_count(4);
    push_item(ACT_EDGE, 4, 0, 1'b0);
    push_eval();
    wait_idle();

    // Back-to-back evaluates while the receiver holds off
    burst = 1'b1;
    repeat (6) begin
      push_item(ACT_EDGE, 0, 1, 1'b1);
      push_item(ACT_EDGE, 1, 0, 1'b1);
      push_eval();
    end
    @(posedge clk_i);
    hold_request <= 1'b1;
    wait_idle();

    // Random graphs over a range of vertex counts
    loaded_items = 0;
    while (loaded_items < RANDOM_ITEMS) begin
      write_vertex_count(pick_vertex_count());
      repeat (GRAPHS_PER_CFG) load_random_graph();
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("eulerian_circuit_check regression: pass");
    end else begin
      $display("eulerian_circuit_check regression: fail");
    end
    $finish;
  end

endmodule
